### sv/ps2md_pkg.sv
`default_nettype none
package ps2md_pkg;

	// Field widths of the request and result channels.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned DELTA_W  = 9;
	localparam int unsigned WHEEL_W  = 4;
	localparam int unsigned BTN_W    = 3;
	localparam int unsigned TOTAL_W  = 32;

	// Request kinds.
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// Position of a byte within a packet.
	localparam logic [1:0] IDX_STATUS = 2'd0;
	localparam logic [1:0] IDX_X      = 2'd1;
	localparam logic [1:0] IDX_Y      = 2'd2;
	localparam logic [1:0] IDX_WHEEL  = 2'd3;

	// Decoding constants.
	localparam logic [7:0] STATUS_KEEP   = 8'h3F;
	localparam logic [7:0] STATUS_XSIGN  = 8'h10;
	localparam logic [7:0] STATUS_YSIGN  = 8'h20;
	localparam logic [7:0] WHEEL_BTN     = 8'h30;
	localparam logic [7:0] WHEEL_MOVE    = 8'h0F;
	localparam logic [7:0] STD_BUTTONS   = 8'h07;
	localparam logic [7:0] ID_WHEEL      = 8'h03;
	localparam logic [7:0] ID_FIVE_BTN   = 8'h04;

endpackage
`default_nettype wire

### sv/ps2md_in_if.sv
`default_nettype none
interface ps2md_in_if
	import ps2md_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface
`default_nettype wire

### sv/ps2md_out_if.sv
`default_nettype none
interface ps2md_out_if
	import ps2md_pkg::*;
	;
	logic                       valid;
	logic                       ready;
	logic signed [DELTA_W-1:0]  delta_x;
	logic signed [DELTA_W-1:0]  delta_y;
	logic signed [WHEEL_W-1:0]  delta_z;
	logic        [BYTE_W-1:0]   button_state;
	logic        [BTN_W-1:0]    pressed_mask;
	logic        [BTN_W-1:0]    released_mask;
	logic                       moved;
	logic signed [TOTAL_W-1:0]  total_x;
	logic signed [TOTAL_W-1:0]  total_y;
	logic signed [TOTAL_W-1:0]  total_z;

	modport source (output valid, output delta_x, output delta_y, output delta_z,
		output button_state, output pressed_mask, output released_mask, output moved,
		output total_x, output total_y, output total_z, input ready);
	modport sink (input valid, input delta_x, input delta_y, input delta_z,
		input button_state, input pressed_mask, input released_mask, input moved,
		input total_x, input total_y, input total_z, output ready);
endinterface
`default_nettype wire

### sv/ps2_mouse_packet_decoder_unit.sv
// PS/2 mouse packet decoder. Each request is one report byte from the mouse or a clear
// command. Bytes are gathered into 3-byte packets, or 4-byte wheel packets when device_id
// is 3 or more (device_id 4 also decodes buttons 4 and 5), and the last byte of a packet
// yields one result with the movement, button state, press and release masks and the
// wrapping 32-bit running totals. A clear zeroes the totals, the button history and the
// packet position without a result. The block takes one request per cycle unless stalled: a
// request is registered in the input stage when it is accepted and decoded from there into
// the result register. A full result register that is not being drained stalls only a
// request that would produce another result or clear the totals.
`default_nettype none
module ps2_mouse_packet_decoder_unit
	import ps2md_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [BYTE_W-1:0] cfg_wr_data,
	ps2md_in_if.sink               in_ch,
	ps2md_out_if.source            out_ch
);

	// Input stage.
	logic              valid_s1;
	logic              kind_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Decoder state.
	logic [BYTE_W-1:0]  device_id_q;
	logic [1:0]         byte_index_q;
	logic [BYTE_W-1:0]  status_hold_q;
	logic [BYTE_W-1:0]  x_hold_q;
	logic [BYTE_W-1:0]  y_hold_q;
	logic [TOTAL_W-1:0] sum_x_q;
	logic [TOTAL_W-1:0] sum_y_q;
	logic [TOTAL_W-1:0] sum_z_q;
	logic [BYTE_W-1:0]  last_buttons_q;

	// Result register.
	logic                valid_s2;
	logic [DELTA_W-1:0]  delta_x_s2;
	logic [DELTA_W-1:0]  delta_y_s2;
	logic [WHEEL_W-1:0]  delta_z_s2;
	logic [BYTE_W-1:0]   buttons_s2;
	logic [BTN_W-1:0]    pressed_s2;
	logic [BTN_W-1:0]    released_s2;
	logic                moved_s2;

	logic               is_clear;
	logic               has_wheel_id;
	logic               finish;
	logic               has_z;
	logic               advance;
	logic               out_free;
	logic [BYTE_W-1:0]  ybyte;
	logic [BYTE_W-1:0]  state_base;
	logic [BYTE_W-1:0]  state_full;
	logic [DELTA_W-1:0] dx;
	logic [DELTA_W-1:0] dy;
	logic [WHEEL_W-1:0] dz;
	logic [BTN_W-1:0]   change;
	logic [1:0]         next_index;

	always_comb begin
		is_clear     = (kind_s1 == KIND_CLEAR);
		has_wheel_id = (device_id_q >= ID_WHEEL);
		finish       = !is_clear && ((byte_index_q == IDX_Y && !has_wheel_id)
			|| byte_index_q == IDX_WHEEL);
		has_z        = (byte_index_q == IDX_WHEEL) && has_wheel_id;
		ybyte        = (byte_index_q == IDX_WHEEL) ? y_hold_q : byte_s1;

		state_base = status_hold_q & STATUS_KEEP;
		state_full = state_base;
		if (has_z && device_id_q == ID_FIVE_BTN) begin
			state_full = state_base | ((byte_s1 & WHEEL_BTN) << 2);
		end

		// A zero byte stays zero even when its sign bit is set.
		dx = {(x_hold_q != '0) && ((state_base & STATUS_XSIGN) != '0), x_hold_q};
		dy = {(ybyte != '0) && ((state_base & STATUS_YSIGN) != '0), ybyte};
		dz = has_z ? byte_s1[WHEEL_W-1:0] : '0;

		change = state_full[BTN_W-1:0] ^ last_buttons_q[BTN_W-1:0];

		case (byte_index_q)
			IDX_STATUS: next_index = IDX_X;
			IDX_X:      next_index = IDX_Y;
			IDX_Y:      next_index = has_wheel_id ? IDX_WHEEL : IDX_STATUS;
			default:    next_index = IDX_STATUS;
		endcase
	end

	// A clear also waits for a pending result, since the shown totals are the running sums.
	assign out_free    = !valid_s2 || out_ch.ready;
	assign advance     = valid_s1 && (!(finish || is_clear) || out_free);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_s1 <= in_ch.kind;
			byte_s1 <= in_ch.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= '0;
		end else if (cfg_wr_en) begin
			device_id_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= IDX_STATUS;
			status_hold_q  <= '0;
			x_hold_q       <= '0;
			y_hold_q       <= '0;
			sum_x_q        <= '0;
			sum_y_q        <= '0;
			sum_z_q        <= '0;
			last_buttons_q <= '0;
		end else if (advance) begin
			if (is_clear) begin
				byte_index_q   <= IDX_STATUS;
				sum_x_q        <= '0;
				sum_y_q        <= '0;
				sum_z_q        <= '0;
				last_buttons_q <= '0;
			end else begin
				byte_index_q <= next_index;
				case (byte_index_q)
					IDX_STATUS: status_hold_q <= byte_s1;
					IDX_X:      x_hold_q      <= byte_s1;
					IDX_Y:      y_hold_q      <= byte_s1;
					default:    ;
				endcase
				if (finish) begin
					sum_x_q        <= sum_x_q + {{(TOTAL_W-DELTA_W){dx[DELTA_W-1]}}, dx};
					sum_y_q        <= sum_y_q + {{(TOTAL_W-DELTA_W){dy[DELTA_W-1]}}, dy};
					sum_z_q        <= sum_z_q + {{(TOTAL_W-WHEEL_W){dz[WHEEL_W-1]}}, dz};
					last_buttons_q <= state_full;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && finish;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && finish) begin
			delta_x_s2  <= dx;
			delta_y_s2  <= dy;
			delta_z_s2  <= dz;
			buttons_s2  <= state_full;
			pressed_s2  <= state_full[BTN_W-1:0] & change;
			released_s2 <= last_buttons_q[BTN_W-1:0] & change;
			moved_s2    <= (dx != '0) || (dy != '0) || (dz != '0);
		end
	end

	// The totals register already holds the post-packet sums while the result is shown.
	assign out_ch.valid         = valid_s2;
	assign out_ch.delta_x       = delta_x_s2;
	assign out_ch.delta_y       = delta_y_s2;
	assign out_ch.delta_z       = delta_z_s2;
	assign out_ch.button_state  = buttons_s2;
	assign out_ch.pressed_mask  = pressed_s2;
	assign out_ch.released_mask = released_s2;
	assign out_ch.moved         = moved_s2;
	assign out_ch.total_x       = sum_x_q;
	assign out_ch.total_y       = sum_y_q;
	assign out_ch.total_z       = sum_z_q;

	// While a result waits, nothing that changes the totals may advance.
	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ch.ready) |-> !advance || (!finish && !is_clear))
		else $error("totals changed under a pending result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && finish) |=> valid_s2)
		else $error("finished packet gave no result");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_clear) |=> (sum_x_q == '0 && sum_y_q == '0 && sum_z_q == '0
			&& byte_index_q == IDX_STATUS && last_buttons_q == '0))
		else $error("clear left state behind");

	a_masks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((pressed_s2 & released_s2) == '0))
		else $error("button both pressed and released");

endmodule
`default_nettype wire
